[rtl/triangle_tangent_generator_unit_macros.svh]
// Assertion macros used by the tangent generator top level.
`ifndef TRIANGLE_TANGENT_GENERATOR_UNIT_MACROS_SVH
`define TRIANGLE_TANGENT_GENERATOR_UNIT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define TTG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Signal must hold its value while a condition is true.
`define TTG_ASSERT_HOLD(label, clk, rst, cond, sig, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
      else $error(msg);
`endif

[rtl/ttg_pkg.sv]
// Package with the types and constants of the triangle tangent generator.
package ttg_pkg;
   localparam int CoordW   = 32;
   localparam int DiffW    = 33;
   localparam int ProdW    = 66;
   localparam int WideW    = 68;
   localparam int NormBits = 30;
   localparam int OutFrac  = 16;
   localparam int OutW     = 18;
   localparam int SqW      = 62;
   localparam int SqrtW    = 31;
   localparam int QW       = 47;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_SHIFT, ST_SQ, ST_SQR, ST_SQRT, ST_DIV, ST_OUT
   } state_type;
endpackage

[rtl/ttg_mul.sv]
// Bit-serial signed multiplier: one multiplier bit per cycle, add and shift.
module ttg_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [ttg_pkg::DiffW-1:0] op_a,
   input  logic signed [ttg_pkg::DiffW-1:0] op_b,
   output logic                         done,
   output logic signed [ttg_pkg::ProdW-1:0] product
);
   logic [ttg_pkg::DiffW-1:0]        mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic [ttg_pkg::ProdW-1:0]        acc_ff, acc_in;
   logic [5:0]                       cnt_ff, cnt_in;
   logic                             busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [ttg_pkg::DiffW-1:0]        abs_a, abs_b;

   always_comb begin
      abs_a = op_a[ttg_pkg::DiffW-1] ? (~op_a + 1'b1) : op_a;
      abs_b = op_b[ttg_pkg::DiffW-1] ? (~op_b + 1'b1) : op_b;
      mag_a_in = mag_a_ff;
      mag_b_in = mag_b_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      if (start) begin
         mag_a_in = abs_a;
         mag_b_in = abs_b;
         acc_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
         neg_in   = op_a[ttg_pkg::DiffW-1] ^ op_b[ttg_pkg::DiffW-1];
      end else if (busy_ff) begin
         // The accumulator holds the partial product, shifted right one bit a cycle.
         acc_in = {1'b0, acc_ff[ttg_pkg::ProdW-1:1]}
                + (mag_b_ff[0] ? {1'b0, mag_a_ff, {(ttg_pkg::ProdW-ttg_pkg::DiffW-1){1'b0}}}
                               : '0);
         mag_b_in = mag_b_ff >> 1;
         cnt_in   = cnt_ff + 6'd1;
         if (cnt_ff == 6'(ttg_pkg::DiffW-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      acc_ff   <= acc_in;
      neg_ff   <= neg_in;
   end

   // After 33 shift-add steps the accumulator holds the full product magnitude.
   assign done    = done_ff;
   assign product = neg_ff ? -$signed(acc_ff) : $signed(acc_ff);
endmodule

[rtl/ttg_sqrt.sv]
// Restoring square root, one result bit per cycle.
module ttg_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ttg_pkg::SqW-1:0]       radicand,
   output logic                          done,
   output logic [ttg_pkg::SqrtW-1:0]     root
);
   logic [ttg_pkg::SqW-1:0]   rem_ff, rem_in;
   logic [ttg_pkg::SqW-1:0]   res_ff, res_in;
   logic [ttg_pkg::SqW-1:0]   bit_ff, bit_in;
   logic                      busy_ff, busy_in, done_ff, done_in;
   logic [ttg_pkg::SqW-1:0]   trial;

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = res_ff + bit_ff;
      if (start) begin
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = {2'b01, {(ttg_pkg::SqW-2){1'b0}}};
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0] || bit_ff[1]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[ttg_pkg::SqrtW-1:0];
endmodule

[rtl/ttg_div.sv]
// Restoring divider, one quotient bit per cycle.
module ttg_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ttg_pkg::QW-1:0]        dividend,
   input  logic [ttg_pkg::SqrtW-1:0]     divisor,
   output logic                          done,
   output logic [ttg_pkg::QW-1:0]        quotient
);
   logic [ttg_pkg::QW-1:0]     quo_ff, quo_in;
   logic [ttg_pkg::SqrtW:0]    rem_ff, rem_in;
   logic [ttg_pkg::SqrtW-1:0]  den_ff, den_in;
   logic [5:0]                 cnt_ff, cnt_in;
   logic                       busy_ff, busy_in, done_ff, done_in;
   logic [ttg_pkg::SqrtW+1:0]  shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[ttg_pkg::QW-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {2'b00, den_ff}) begin
            rem_in = (ttg_pkg::SqrtW+1)'(shifted - {2'b00, den_ff});
            quo_in = {quo_ff[ttg_pkg::QW-2:0], 1'b1};
         end else begin
            rem_in = shifted[ttg_pkg::SqrtW:0];
            quo_in = {quo_ff[ttg_pkg::QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(ttg_pkg::QW-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

[rtl/triangle_tangent_generator_unit.sv]
// Top level of the triangle tangent generator: corner store, sequencer, serial units.
//   channel | dir | tdata fields (low bit up)                        | tuser
//   req     | in  | pos_x pos_y pos_z tex_u tex_v (160 bits)         | -
//   rsp     | out | tangent_x tangent_y tangent_z (54 bits, pad 56)  | degenerate
// The first two corners of a triangle are only stored in the corner store.
// The third corner runs eight products and three squares on one shift-add multiplier,
// a square root and three divides; a degenerate triangle stops after the eight products.
// Reset is synchronous and clears the corner count and the sequencer.
// The output register holds a word until it is taken; the next triangle's first two corners
// are taken meanwhile and its third waits.
`include "triangle_tangent_generator_unit_macros.svh"
module triangle_tangent_generator_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [159:0] req_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata,   // tangent_x, tangent_y, tangent_z, zero pad
   output logic         rsp_tuser    // degenerate
);
   localparam int CW = ttg_pkg::CoordW;
   localparam int DW = ttg_pkg::DiffW;
   localparam int PW = ttg_pkg::ProdW;
   localparam int WW = ttg_pkg::WideW;

   ttg_pkg::state_type state_ff, state_in;
   logic [1:0]  corner_ff, corner_in;
   logic signed [CW-1:0] p0_ff [3];
   logic signed [CW-1:0] p1_ff [3];
   logic signed [CW-1:0] p2_ff [3];
   logic signed [CW-1:0] t0_ff [2];
   logic signed [CW-1:0] t1_ff [2];
   logic signed [CW-1:0] t2_ff [2];
   logic signed [PW-1:0] prod_ff [8];
   logic [2:0]  step_ff, step_in;
   logic        issued_ff, issued_in;
   logic [WW-1:0] mag_ff [3];
   logic          neg_ff [3];
   logic          dneg_ff;
   logic [ttg_pkg::NormBits-1:0] a_ff [3];
   logic [ttg_pkg::SqW-1:0] sum_ff;
   logic [ttg_pkg::SqrtW-1:0] len_ff;
   logic [ttg_pkg::OutW-1:0]  out_ff [3];
   logic          out_deg_ff;
   logic          res_valid_ff, res_deg_ff;
   logic [ttg_pkg::OutW-1:0] res_t_ff [3];

   logic mul_start, mul_done;
   logic signed [DW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] mul_p;
   logic sq_start, sq_done, dv_start, dv_done;
   logic [ttg_pkg::SqrtW-1:0] sq_root;
   logic [ttg_pkg::QW-1:0] dv_q;

   logic accept;
   logic signed [WW-1:0] det, wv [3];
   logic [6:0] blen [3];
   logic [6:0] maxlen;
   logic [ttg_pkg::QW-1:0] num;
   logic [ttg_pkg::QW-1:0] qclamp;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == ttg_pkg::ST_IDLE) && (corner_ff != 2'd2 || !res_valid_ff);

   // Operands of the eight products: det terms, then W terms per axis.
   // The squares of the normalized components reuse the same multiplier.
   always_comb begin
      logic signed [DW-1:0] d1u, d1v, d2u, d2v;
      d1u = DW'(t1_ff[0]) - DW'(t0_ff[0]);
      d1v = DW'(t1_ff[1]) - DW'(t0_ff[1]);
      d2u = DW'(t2_ff[0]) - DW'(t0_ff[0]);
      d2v = DW'(t2_ff[1]) - DW'(t0_ff[1]);
      mul_a = d1u;
      mul_b = d2v;
      unique case (step_ff)
         3'd0: begin mul_a = d1u; mul_b = d2v; end
         3'd1: begin mul_a = d2u; mul_b = d1v; end
         3'd2: begin mul_a = d2v; mul_b = DW'(p1_ff[0]) - DW'(p0_ff[0]); end
         3'd3: begin mul_a = d1v; mul_b = DW'(p2_ff[0]) - DW'(p0_ff[0]); end
         3'd4: begin mul_a = d2v; mul_b = DW'(p1_ff[1]) - DW'(p0_ff[1]); end
         3'd5: begin mul_a = d1v; mul_b = DW'(p2_ff[1]) - DW'(p0_ff[1]); end
         3'd6: begin mul_a = d2v; mul_b = DW'(p1_ff[2]) - DW'(p0_ff[2]); end
         default: begin mul_a = d1v; mul_b = DW'(p2_ff[2]) - DW'(p0_ff[2]); end
      endcase
      if (state_ff == ttg_pkg::ST_SQR) begin
         mul_a = DW'(a_ff[step_ff[1:0]]);
         mul_b = DW'(a_ff[step_ff[1:0]]);
      end
   end

   ttg_mul u_mul (.clock, .reset, .start(mul_start), .op_a(mul_a), .op_b(mul_b),
                  .done(mul_done), .product(mul_p));
   ttg_sqrt u_sqrt (.clock, .reset, .start(sq_start), .radicand(sum_ff),
                    .done(sq_done), .root(sq_root));
   ttg_div u_div (.clock, .reset, .start(dv_start), .dividend(num), .divisor(len_ff),
                  .done(dv_done), .quotient(dv_q));

   always_comb begin
      det = WW'(prod_ff[0]) - WW'(prod_ff[1]);
      for (int i = 0; i < 3; i++) begin
         wv[i] = WW'(prod_ff[2*i+2]) - WW'(prod_ff[2*i+3]);
         blen[i] = '0;
         for (int b = 0; b < WW; b++) if (mag_ff[i][b]) blen[i] = 7'(b + 1);
      end
      maxlen = blen[0];
      if (blen[1] > maxlen) maxlen = blen[1];
      if (blen[2] > maxlen) maxlen = blen[2];
      num = {a_ff[step_ff[1:0]], {ttg_pkg::OutFrac{1'b0}}} + ttg_pkg::QW'(len_ff >> 1);
      qclamp = (dv_q > ttg_pkg::QW'(65536)) ? ttg_pkg::QW'(65536) : dv_q;
   end

   always_comb begin
      state_in  = state_ff;
      corner_in = corner_ff;
      step_in   = step_ff;
      issued_in = issued_ff;
      mul_start = 1'b0;
      sq_start  = 1'b0;
      dv_start  = 1'b0;
      unique case (state_ff)
         ttg_pkg::ST_IDLE: begin
            if (accept) begin
               corner_in = (corner_ff == 2'd2) ? 2'd0 : corner_ff + 2'd1;
               if (corner_ff == 2'd2) begin
                  state_in = ttg_pkg::ST_MUL;
                  step_in = '0;
                  issued_in = 1'b0;
               end
            end
         end
         ttg_pkg::ST_MUL: begin
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (mul_done) begin
               issued_in = 1'b0;
               step_in = step_ff + 3'd1;
               if (step_ff == 3'd7) state_in = ttg_pkg::ST_SHIFT;
            end
         end
         ttg_pkg::ST_SHIFT: state_in = ttg_pkg::ST_SQ;
         ttg_pkg::ST_SQ: begin
            if (det == '0 || (wv[0] == '0 && wv[1] == '0 && wv[2] == '0)) begin
               state_in = ttg_pkg::ST_OUT;
            end else begin
               state_in = ttg_pkg::ST_SQR;
               step_in = '0;
               issued_in = 1'b0;
            end
         end
         ttg_pkg::ST_SQR: begin
            if (!issued_ff) begin
               mul_start = 1'b1;
               issued_in = 1'b1;
            end else if (mul_done) begin
               issued_in = 1'b0;
               step_in = step_ff + 3'd1;
               if (step_ff == 3'd2) state_in = ttg_pkg::ST_SQRT;
            end
         end
         ttg_pkg::ST_SQRT: begin
            if (!issued_ff) begin
               sq_start = 1'b1;
               issued_in = 1'b1;
            end else if (sq_done) begin
               issued_in = 1'b0;
               step_in = '0;
               state_in = ttg_pkg::ST_DIV;
            end
         end
         ttg_pkg::ST_DIV: begin
            if (!issued_ff) begin
               dv_start = 1'b1;
               issued_in = 1'b1;
            end else if (dv_done) begin
               issued_in = 1'b0;
               step_in = step_ff + 3'd1;
               if (step_ff == 3'd2) state_in = ttg_pkg::ST_OUT;
            end
         end
         ttg_pkg::ST_OUT: if (!res_valid_ff) state_in = ttg_pkg::ST_IDLE;
         default: state_in = ttg_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttg_pkg::ST_IDLE;
         corner_ff    <= '0;
         step_ff      <= '0;
         issued_ff    <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         corner_ff <= corner_in;
         step_ff   <= step_in;
         issued_ff <= issued_in;
         if (rsp_tvalid && rsp_tready) res_valid_ff <= 1'b0;
         if (state_ff == ttg_pkg::ST_OUT && !res_valid_ff) res_valid_ff <= 1'b1;
      end
      if (accept) begin
         for (int i = 0; i < 3; i++) begin
            unique case (corner_ff)
               2'd0: p0_ff[i] <= req_tdata[CW*i +: CW];
               2'd1: p1_ff[i] <= req_tdata[CW*i +: CW];
               default: p2_ff[i] <= req_tdata[CW*i +: CW];
            endcase
         end
         for (int i = 0; i < 2; i++) begin
            unique case (corner_ff)
               2'd0: t0_ff[i] <= req_tdata[CW*(i+3) +: CW];
               2'd1: t1_ff[i] <= req_tdata[CW*(i+3) +: CW];
               default: t2_ff[i] <= req_tdata[CW*(i+3) +: CW];
            endcase
         end
      end
      if (state_ff == ttg_pkg::ST_MUL && issued_ff && mul_done) prod_ff[step_ff] <= mul_p;
      if (state_ff == ttg_pkg::ST_SHIFT) begin
         dneg_ff <= det[WW-1];
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= wv[i][WW-1];
            mag_ff[i] <= wv[i][WW-1] ? WW'(-wv[i]) : wv[i];
         end
      end
      if (state_ff == ttg_pkg::ST_SQ) begin
         logic [ttg_pkg::NormBits-1:0] av [3];
         for (int i = 0; i < 3; i++) begin
            if (maxlen > 7'(ttg_pkg::NormBits))
               av[i] = ttg_pkg::NormBits'(mag_ff[i] >> (maxlen - 7'(ttg_pkg::NormBits)));
            else
               av[i] = ttg_pkg::NormBits'(mag_ff[i] << (7'(ttg_pkg::NormBits) - maxlen));
            a_ff[i] <= av[i];
            out_ff[i] <= '0;
         end
         sum_ff <= '0;
         out_deg_ff <= (det == '0 || (wv[0] == '0 && wv[1] == '0 && wv[2] == '0));
      end
      if (state_ff == ttg_pkg::ST_SQR && issued_ff && mul_done)
         sum_ff <= sum_ff + ttg_pkg::SqW'(mul_p);
      if (state_ff == ttg_pkg::ST_SQRT && sq_done) len_ff <= sq_root;
      if (state_ff == ttg_pkg::ST_DIV && issued_ff && dv_done)
         out_ff[step_ff[1:0]] <= (neg_ff[step_ff[1:0]] != dneg_ff)
            ? ttg_pkg::OutW'(-qclamp) : ttg_pkg::OutW'(qclamp);
      if (state_ff == ttg_pkg::ST_OUT && !res_valid_ff) begin
         res_deg_ff <= out_deg_ff;
         for (int i = 0; i < 3; i++) res_t_ff[i] <= out_ff[i];
      end
   end

   assign rsp_tvalid = res_valid_ff;
   assign rsp_tdata  = {2'b00, res_t_ff[2], res_t_ff[1], res_t_ff[0]};
   assign rsp_tuser  = res_deg_ff;

   `TTG_ASSERT(a_no_take_busy, clock, reset,
      (state_ff != ttg_pkg::ST_IDLE) |-> !req_tready, "corner taken while busy")
   `TTG_ASSERT_HOLD(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tdata,
      "result word changed while stalled")
   `TTG_ASSERT(a_corner_range, clock, reset, corner_ff != 2'd3, "corner count out of range")
endmodule
